/* design/cia_pkg.sv */
// Shared types and constants for the checked integer ALU.
`timescale 1ns / 1ps
`default_nettype none
package cia_pkg;

  localparam int unsigned XLen     = 64;
  localparam int unsigned DivSteps = 64;

  localparam logic [XLen-1:0] SignBit = {1'b1, {(XLen-1){1'b0}}};

  typedef enum logic [4:0] {
    OpAdd      = 5'd0,
    OpSub      = 5'd1,
    OpMul      = 5'd2,
    OpDiv      = 5'd3,
    OpMod      = 5'd4,
    OpAnd      = 5'd5,
    OpOr       = 5'd6,
    OpXor      = 5'd7,
    OpShl      = 5'd8,
    OpShr      = 5'd9,
    OpEq       = 5'd10,
    OpNe       = 5'd11,
    OpThreeway = 5'd12,
    OpLt       = 5'd13,
    OpLe       = 5'd14,
    OpGt       = 5'd15,
    OpGe       = 5'd16,
    OpLand     = 5'd17,
    OpLor      = 5'd18,
    OpComma    = 5'd19
  } op_e;

  typedef enum logic [2:0] {
    ErrNone        = 3'd0,
    ErrOverflow    = 3'd1,
    ErrDivZero     = 3'd2,
    ErrModZero     = 3'd3,
    ErrBadShift    = 3'd4,
    ErrUnsupported = 3'd5
  } err_e;

  // One request as it travels down the pipeline
  typedef struct packed {
    logic [4:0]      op;
    logic            umode;
    logic [XLen-1:0] mask;
    logic [XLen-1:0] opa;    // raw or magnitude; quotient bits shift in during divide
    logic [XLen-1:0] opb;    // raw or magnitude; divisor
    logic            neg_q;
    logic            neg_r;
    logic [XLen-1:0] res;
    err_e            err;
  } item_t;

endpackage
`default_nettype wire

/* design/cia_front.sv */
// Decode stage: simple operations, error checks and operand preparation.
`timescale 1ns / 1ps
`default_nettype none
module cia_front #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire logic [4:0]             opcode_i,
  input  wire logic [63:0]            left_operand_i,
  input  wire logic [63:0]            right_operand_i,
  input  wire logic                   unsigned_mode_i,
  input  wire logic [1:0]             width_code_i,
  output logic                        valid_o,
  output cia_pkg::item_t              item_o
);

  localparam logic [6:0] WidthCap = 7'(DATA_WIDTH);

  logic [6:0]     w;
  logic [63:0]    mask, a, b, ma, mb, sum, dif, shl, shr_u, sar, r;
  logic [5:0]     sh;
  logic           bad_sh, slt_ab, slt_ba, ult, eq;
  cia_pkg::err_e  err;
  cia_pkg::item_t it_d, it_q;
  logic           v_q;

  // Width and mask
  always_comb begin
    w = 7'd8 << width_code_i;
    if (w > WidthCap) w = WidthCap;
    mask = (w >= 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
  end

  assign a      = left_operand_i;
  assign b      = right_operand_i;
  assign sh     = b[5:0];
  assign sum    = a + b;
  assign dif    = a - b;
  assign shl    = a << sh;
  assign shr_u  = a >> sh;
  assign sar    = 64'($signed(a) >>> sh);
  assign slt_ab = $signed(a) < $signed(b);
  assign slt_ba = $signed(b) < $signed(a);
  assign ult    = a < b;
  assign eq     = a == b;
  assign ma     = (!unsigned_mode_i && a[63]) ? (64'd0 - a) : a;
  assign mb     = (!unsigned_mode_i && b[63]) ? (64'd0 - b) : b;
  assign bad_sh = (!unsigned_mode_i && b[63]) || (b >= {57'd0, w});

  // Result and error for everything but the multiply and divide units
  always_comb begin
    r   = '0;
    err = cia_pkg::ErrNone;
    case (opcode_i)
      cia_pkg::OpAdd: begin
        if (unsigned_mode_i) r = sum & mask;
        else if (((a ^ sum) & (b ^ sum) & cia_pkg::SignBit) != '0) err = cia_pkg::ErrOverflow;
        else r = sum;
      end
      cia_pkg::OpSub: begin
        if (unsigned_mode_i) r = dif & mask;
        else if (((a ^ b) & (a ^ dif) & cia_pkg::SignBit) != '0) err = cia_pkg::ErrOverflow;
        else r = dif;
      end
      cia_pkg::OpMul: r = '0;
      cia_pkg::OpDiv: begin
        if (b == '0) err = cia_pkg::ErrDivZero;
        else if (!unsigned_mode_i && a == cia_pkg::SignBit && b == '1)
          err = cia_pkg::ErrOverflow;
      end
      cia_pkg::OpMod: begin
        if (b == '0) err = cia_pkg::ErrModZero;
      end
      cia_pkg::OpAnd: r = unsigned_mode_i ? (a & b & mask) : (a & b);
      cia_pkg::OpOr:  r = unsigned_mode_i ? ((a | b) & mask) : (a | b);
      cia_pkg::OpXor: r = unsigned_mode_i ? ((a ^ b) & mask) : (a ^ b);
      cia_pkg::OpShl: begin
        if (bad_sh) err = cia_pkg::ErrBadShift;
        else if (unsigned_mode_i) r = shl & mask;
        else if (a == '0) r = '0;
        else if (64'($signed(shl) >>> sh) != a) err = cia_pkg::ErrOverflow;
        else r = shl;
      end
      cia_pkg::OpShr: begin
        if (bad_sh) err = cia_pkg::ErrBadShift;
        else r = unsigned_mode_i ? (shr_u & mask) : sar;
      end
      cia_pkg::OpEq: r = {63'd0, eq};
      cia_pkg::OpNe: r = {63'd0, !eq};
      cia_pkg::OpThreeway: begin
        if (unsigned_mode_i ? ult : slt_ab) r = '1;
        else r = {63'd0, !eq};
      end
      cia_pkg::OpLt: r = {63'd0, unsigned_mode_i ? ult : slt_ab};
      cia_pkg::OpLe: r = {63'd0, unsigned_mode_i ? (ult || eq) : !slt_ba};
      cia_pkg::OpGt: r = {63'd0, unsigned_mode_i ? !(ult || eq) : slt_ba};
      cia_pkg::OpGe: r = {63'd0, unsigned_mode_i ? !ult : !slt_ab};
      cia_pkg::OpLand: r = {63'd0, (a != '0) && (b != '0)};
      cia_pkg::OpLor:  r = {63'd0, (a != '0) || (b != '0)};
      cia_pkg::OpComma: begin
        if (unsigned_mode_i) err = cia_pkg::ErrUnsupported;
        else r = b;
      end
      default: err = cia_pkg::ErrUnsupported;
    endcase
  end

  always_comb begin
    it_d.op    = opcode_i;
    it_d.umode = unsigned_mode_i;
    it_d.mask  = mask;
    it_d.opa   = ma;
    it_d.opb   = mb;
    it_d.neg_q = !unsigned_mode_i && (a[63] ^ b[63]);
    it_d.neg_r = !unsigned_mode_i && a[63];
    it_d.res   = r;
    it_d.err   = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d;
  end

  assign valid_o = v_q;
  assign item_o  = it_q;

endmodule
`default_nettype wire

/* design/cia_mul.sv */
// Three-stage 64x64 multiplier with signed overflow check.
`timescale 1ns / 1ps
`default_nettype none
module cia_mul (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  cia_pkg::item_t      item_i,
  output logic                valid_o,
  output cia_pkg::item_t      item_o
);

  logic [2:0]      v_q;
  cia_pkg::item_t  it_a_q, it_b_q, it_c_d, it_c_q;
  logic [63:0]     pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [127:0]    prod_q;
  logic [63:0]     q;
  logic            ovf;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // Stage A: 32x32 partial products
  always_ff @(posedge clk_i) begin
    it_a_q  <= item_i;
    pp_ll_q <= 64'(item_i.opa[31:0])  * 64'(item_i.opb[31:0]);
    pp_lh_q <= 64'(item_i.opa[31:0])  * 64'(item_i.opb[63:32]);
    pp_hl_q <= 64'(item_i.opa[63:32]) * 64'(item_i.opb[31:0]);
    pp_hh_q <= 64'(item_i.opa[63:32]) * 64'(item_i.opb[63:32]);
  end

  // Stage B: sum of partial products
  always_ff @(posedge clk_i) begin
    it_b_q <= it_a_q;
    prod_q <= {64'd0, pp_ll_q} + ({64'd0, pp_lh_q} << 32) + ({64'd0, pp_hl_q} << 32)
            + {pp_hh_q, 64'd0};
  end

  // Stage C: wrap, or range check and sign
  assign q = prod_q[63:0];
  always_comb begin
    it_c_d = it_b_q;
    ovf    = (prod_q[127:64] != '0) ||
             (it_b_q.neg_q ? (q > cia_pkg::SignBit) : (q > (cia_pkg::SignBit - 64'd1)));
    if (it_b_q.op == cia_pkg::OpMul) begin
      if (it_b_q.umode) begin
        it_c_d.res = q & it_b_q.mask;
      end else if (ovf) begin
        it_c_d.err = cia_pkg::ErrOverflow;
      end else begin
        it_c_d.res = it_b_q.neg_q ? (64'd0 - q) : q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    it_c_q <= it_c_d;
  end

  assign valid_o = v_q[2];
  assign item_o  = it_c_q;

endmodule
`default_nettype wire

/* design/cia_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cia_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  cia_pkg::item_t      item_i,
  output logic                valid_o,
  output cia_pkg::item_t      item_o,
  output logic [63:0]         rem_o
);

  localparam int unsigned N = cia_pkg::DivSteps;

  logic [N-1:0]   v_q;
  cia_pkg::item_t it_q   [N];
  logic [63:0]    rem_q  [N];
  cia_pkg::item_t it_src [N];
  logic [63:0]    rem_src[N];
  cia_pkg::item_t it_nxt [N];
  logic [63:0]    rem_nxt[N];
  logic [64:0]    t      [N];
  logic [64:0]    diff   [N];
  logic           ge     [N];

  // Stage sources: the input for the first, the previous stage otherwise
  always_comb begin
    it_src[0]  = item_i;
    rem_src[0] = '0;
    for (int i = 1; i < N; i++) begin
      it_src[i]  = it_q[i-1];
      rem_src[i] = rem_q[i-1];
    end
  end

  // One shift-compare-subtract step per stage; quotient bits shift into opa
  always_comb begin
    for (int i = 0; i < N; i++) begin
      t[i]          = {rem_src[i], it_src[i].opa[63]};
      diff[i]       = t[i] - {1'b0, it_src[i].opb};
      ge[i]         = t[i] >= {1'b0, it_src[i].opb};
      it_nxt[i]     = it_src[i];
      it_nxt[i].opa = {it_src[i].opa[62:0], ge[i]};
      rem_nxt[i]    = ge[i] ? diff[i][63:0] : t[i][63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      it_q[i]  <= it_nxt[i];
      rem_q[i] <= rem_nxt[i];
    end
  end

  assign valid_o = v_q[N-1];
  assign item_o  = it_q[N-1];
  assign rem_o   = rem_q[N-1];

endmodule
`default_nettype wire

/* design/checked_integer_alu.sv */
// Top level of the checked 64-bit integer ALU.
// Usage: drive opcode_i, left_operand_i, right_operand_i, unsigned_mode_i and
// width_code_i with start high; the request is taken at that clock edge
// whenever busy is low. busy is always low, so a new request may be issued
// in every cycle.
// Each result appears on result_value_o and error_code_o for exactly one
// cycle, marked by done_o, after its request has passed one decode stage,
// three multiplier stages, 64 divider stages (one quotient bit each) and
// one output stage. Every request passes through all stages, so results
// leave in request order at up to one per cycle.
// Throughput is one request per cycle.
// Reset clears all valid bits: no strobe follows until new requests arrive.
// The receiver cannot stall; results must be taken as they are strobed.
// Any error returns a result value of zero.
`timescale 1ns / 1ps
`default_nettype none
module checked_integer_alu #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [4:0]  opcode_i,
  input  wire logic [63:0] left_operand_i,
  input  wire logic [63:0] right_operand_i,
  input  wire logic        unsigned_mode_i,
  input  wire logic [1:0]  width_code_i,
  output logic             done_o,
  output logic [63:0]      result_value_o,
  output logic [2:0]       error_code_o
);

  logic           f_v, m_v, d_v;
  cia_pkg::item_t f_it, m_it, d_it;
  logic [63:0]    d_rem, quo, val_d, val_q;
  logic [2:0]     err_q;
  logic           done_q;

  assign busy = 1'b0;

  cia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .valid_i(start && !busy),
    .opcode_i, .left_operand_i, .right_operand_i, .unsigned_mode_i, .width_code_i,
    .valid_o(f_v), .item_o(f_it)
  );

  cia_mul u_mul (
    .clk_i, .rst_ni, .valid_i(f_v), .item_i(f_it), .valid_o(m_v), .item_o(m_it)
  );

  cia_div u_div (
    .clk_i, .rst_ni, .valid_i(m_v), .item_i(m_it),
    .valid_o(d_v), .item_o(d_it), .rem_o(d_rem)
  );

  // Output stage: divide and modulo fix-up, zero on error
  assign quo = d_it.opa;
  always_comb begin
    val_d = d_it.res;
    case (d_it.op)
      cia_pkg::OpDiv: val_d = d_it.umode ? (quo & d_it.mask)
                                         : (d_it.neg_q ? (64'd0 - quo) : quo);
      cia_pkg::OpMod: val_d = d_it.umode ? (d_rem & d_it.mask)
                                         : (d_it.neg_r ? (64'd0 - d_rem) : d_rem);
      default:        val_d = d_it.res;
    endcase
    if (d_it.err != cia_pkg::ErrNone) val_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    err_q <= d_it.err;
  end

  assign done_o         = done_q;
  assign result_value_o = val_q;
  assign error_code_o   = err_q;

endmodule
`default_nettype wire
